@@ hw/rtl/ile_pkg.sv @@
// ============================================================================
// ile_pkg - shared types and constants of the interactive line editor
// Key codes, key classes, result status codes, the command and status
// bundles between controller and datapath, and the key decoder.
// ============================================================================
package ile_pkg;

    // Field types
    typedef logic [8:0] t_key;
    typedef logic [6:0] t_char;
    typedef logic [6:0] t_cap;
    typedef logic [5:0] t_pos;

    // Special key codes
    localparam t_key KC_LEFT        = 9'd256;
    localparam t_key KC_RIGHT       = 9'd257;
    localparam t_key KC_ESCAPE      = 9'd258;
    localparam t_key KC_NONE        = 9'd259;
    localparam t_key KC_DELETE      = 9'd260;
    localparam t_key KC_HOME        = 9'd261;
    localparam t_key KC_END         = 9'd262;
    localparam t_key KC_CTRL_DELETE = 9'd263;

    // ASCII control and printable codes with a role
    localparam t_key KC_CTRL_C      = 9'd3;
    localparam t_key KC_BACKSPACE   = 9'd8;
    localparam t_key KC_TAB         = 9'd9;
    localparam t_key KC_LF          = 9'd10;
    localparam t_key KC_CR          = 9'd13;
    localparam t_key KC_CTRL_W      = 9'd23;
    localparam t_key KC_SPACE       = 9'd32;
    localparam t_key KC_TILDE       = 9'd126;
    localparam t_key KC_DEL_ASCII   = 9'd127;

    // Blank characters for word deletion
    localparam t_char CH_TAB   = 7'd9;
    localparam t_char CH_CR    = 7'd13;
    localparam t_char CH_SPACE = 7'd32;

    // Reset value of the capacity register
    localparam t_cap CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_CONTINUE  = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_CANCELLED = 2'd2,
        ST_NO_INPUT  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LEFT,
        OP_RIGHT,
        OP_DELETE,
        OP_HOME,
        OP_END,
        OP_CDEL,
        OP_ENTER,
        OP_CANCEL,
        OP_BKSP,
        OP_CWORD,
        OP_INSERT,
        OP_IGNORE
    } t_key_op;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SCAN_F,
        CMD_SCAN_B,
        CMD_CUT,
        CMD_CUT_END,
        CMD_INS,
        CMD_INS_END,
        CMD_PUT,
        CMD_EMIT
    } t_dp_cmd;

    // Controller to datapath
    typedef struct packed {
        t_dp_cmd cmd;
        t_key_op op;
        logic    res;
        t_status res_status;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic len_zero;
        logic cur_zero;
        logic cur_lt_len;
        logic ins_ok;
        logic stop_f;
        logic stop_b;
        logic cut_more;
        logic ins_more;
        logic emit_last;
    } t_sts;

    // Sort a key code into its editing class
    function automatic t_key_op decode_key(input t_key k);
        t_key_op op;
        priority if (k == KC_NONE)                           op = OP_NONE;
        else if (k == KC_LEFT)                               op = OP_LEFT;
        else if (k == KC_RIGHT)                              op = OP_RIGHT;
        else if (k == KC_DELETE)                             op = OP_DELETE;
        else if (k == KC_HOME)                               op = OP_HOME;
        else if (k == KC_END)                                op = OP_END;
        else if (k == KC_CTRL_DELETE)                        op = OP_CDEL;
        else if (k == KC_LF || k == KC_CR)                   op = OP_ENTER;
        else if (k == KC_CTRL_C || k == KC_ESCAPE)           op = OP_CANCEL;
        else if (k == KC_BACKSPACE || k == KC_DEL_ASCII)     op = OP_BKSP;
        else if (k == KC_CTRL_W)                             op = OP_CWORD;
        else if ((k >= KC_SPACE && k <= KC_TILDE) || k == KC_TAB) op = OP_INSERT;
        else                                                 op = OP_IGNORE;
        return op;
    endfunction

    // Space and the codes from tab to carriage return count as blank
    function automatic logic is_blank(input t_char ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

endpackage

@@ hw/rtl/ile_ram.sv @@
// ============================================================================
// ile_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module ile_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ile_ctrl.sv @@
// ============================================================================
// ile_ctrl - sequencer of the line editor
// Decodes the key, picks the edit sequence, steps through scan, move, insert
// and emission phases, requesting a result strobe at the end or per character.
// ============================================================================
module ile_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ile_pkg::t_key i_key_code,
    input  ile_pkg::t_sts i_sts,
    output ile_pkg::t_ctl o_ctl,
    output logic          o_busy
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN_F  = 9'b000000010,
        S_SCAN_B  = 9'b000000100,
        S_CUT     = 9'b000001000,
        S_CUT_END = 9'b000010000,
        S_INS     = 9'b000100000,
        S_INS_END = 9'b001000000,
        S_PUT     = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    ile_pkg::t_key_op op;

    assign op = ile_pkg::decode_key(i_key_code);

    // Next state and datapath command
    always_comb begin
        n_state          = r_state;
        o_ctl.cmd        = ile_pkg::CMD_NOP;
        o_ctl.op         = op;
        o_ctl.res        = 1'b0;
        o_ctl.res_status = ile_pkg::ST_CONTINUE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cmd = ile_pkg::CMD_LOAD;
                    o_ctl.res = 1'b1;
                    unique case (op)
                        ile_pkg::OP_NONE: begin
                            o_ctl.res_status = ile_pkg::ST_NO_INPUT;
                        end
                        ile_pkg::OP_CANCEL: begin
                            o_ctl.res_status = ile_pkg::ST_CANCELLED;
                        end
                        ile_pkg::OP_DELETE: begin
                            if (i_sts.cur_lt_len) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_CUT;
                            end
                        end
                        ile_pkg::OP_CDEL: begin
                            if (i_sts.cur_lt_len) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_SCAN_F;
                            end
                        end
                        ile_pkg::OP_BKSP: begin
                            if (!i_sts.cur_zero) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_CUT;
                            end else if (i_sts.len_zero) begin
                                o_ctl.res_status = ile_pkg::ST_CANCELLED;
                            end
                        end
                        ile_pkg::OP_CWORD: begin
                            if (!i_sts.cur_zero) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_SCAN_B;
                            end else if (i_sts.len_zero) begin
                                o_ctl.res_status = ile_pkg::ST_CANCELLED;
                            end
                        end
                        ile_pkg::OP_ENTER: begin
                            o_ctl.res_status = ile_pkg::ST_ACCEPTED;
                            if (!i_sts.len_zero) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_EMIT;
                            end
                        end
                        ile_pkg::OP_INSERT: begin
                            if (i_sts.ins_ok) begin
                                o_ctl.res = 1'b0;
                                n_state   = S_INS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN_F: begin
                o_ctl.cmd = ile_pkg::CMD_SCAN_F;
                if (i_sts.stop_f) begin
                    n_state = S_CUT;
                end
            end
            S_SCAN_B: begin
                o_ctl.cmd = ile_pkg::CMD_SCAN_B;
                if (i_sts.stop_b) begin
                    n_state = S_CUT;
                end
            end
            S_CUT: begin
                o_ctl.cmd = ile_pkg::CMD_CUT;
                if (!i_sts.cut_more) begin
                    n_state = S_CUT_END;
                end
            end
            S_CUT_END: begin
                o_ctl.cmd = ile_pkg::CMD_CUT_END;
                o_ctl.res = 1'b1;
                n_state   = S_IDLE;
            end
            S_INS: begin
                o_ctl.cmd = ile_pkg::CMD_INS;
                if (!i_sts.ins_more) begin
                    n_state = S_INS_END;
                end
            end
            S_INS_END: begin
                o_ctl.cmd = ile_pkg::CMD_INS_END;
                n_state   = S_PUT;
            end
            S_PUT: begin
                o_ctl.cmd = ile_pkg::CMD_PUT;
                o_ctl.res = 1'b1;
                n_state   = S_IDLE;
            end
            S_EMIT: begin
                o_ctl.cmd        = ile_pkg::CMD_EMIT;
                o_ctl.res        = 1'b1;
                o_ctl.res_status = ile_pkg::ST_ACCEPTED;
                if (i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/ile_dpath.sv @@
// ============================================================================
// ile_dpath - line store, pointers and result register of the line editor
// Holds length, cursor, scan and move pointers and the capacity register;
// moves store entries one per cycle through a pipelined read/write pair.
// ============================================================================
module ile_dpath #(
    parameter int LINE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ile_pkg::t_ctl    i_ctl,
    input  ile_pkg::t_key    i_key_code,
    input  logic             i_cfg_we,
    input  ile_pkg::t_cap    i_cfg_wdata,
    output ile_pkg::t_sts    o_sts,
    output logic             o_strobe,
    output ile_pkg::t_status o_status,
    output ile_pkg::t_pos    o_line_length,
    output ile_pkg::t_pos    o_cursor_position,
    output ile_pkg::t_char   o_out_char,
    output logic             o_char_valid,
    output logic             o_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] ONE = AW'(1);

    // Architectural and sequencing registers
    logic [AW-1:0]  r_len, n_len;
    logic [AW-1:0]  r_cur, n_cur;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [AW-1:0]  r_dst, n_dst;
    logic [AW-1:0]  r_waddr, n_waddr;
    logic           r_wpend, n_wpend;
    logic           r_phase, n_phase;
    ile_pkg::t_char r_char, n_char;
    ile_pkg::t_cap  r_cap;

    // Result register
    logic             r_strobe;
    ile_pkg::t_status r_o_status;
    ile_pkg::t_pos    r_o_len;
    ile_pkg::t_pos    r_o_cur;
    ile_pkg::t_char   r_o_char;
    logic             r_o_cv;
    logic             r_o_last;

    // Store port signals
    logic           we;
    logic [AW-1:0]  waddr;
    ile_pkg::t_char wdata;
    logic [AW-1:0]  rd_addr;
    ile_pkg::t_char q;
    logic           blank_q;
    logic [8:0]     cap_eff;
    logic           emit;

    ile_ram #(
        .WIDTH ($bits(ile_pkg::t_char)),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (q)
    );

    assign blank_q = ile_pkg::is_blank(q);
    assign emit    = (i_ctl.cmd == ile_pkg::CMD_EMIT);

    // Clamp the capacity to the store depth
    assign cap_eff = (9'(r_cap) > 9'(LINE_DEPTH)) ? 9'(LINE_DEPTH) : 9'(r_cap);

    // Status towards the controller
    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.cur_zero   = (r_cur == '0);
    assign o_sts.cur_lt_len = (r_cur < r_len);
    assign o_sts.ins_ok     = ((9'(r_len) + 9'd1) < cap_eff);
    assign o_sts.stop_f     = (r_ptr >= r_len) || (r_phase && !blank_q);
    assign o_sts.stop_b     = (r_ptr == '0) || (r_phase && blank_q);
    assign o_sts.cut_more   = (r_ptr < r_len);
    assign o_sts.ins_more   = (r_dst > r_cur);
    assign o_sts.emit_last  = ((r_ptr + ONE) == r_dst);

    // Next-state logic for each command
    always_comb begin
        n_len   = r_len;
        n_cur   = r_cur;
        n_ptr   = r_ptr;
        n_dst   = r_dst;
        n_phase = r_phase;
        n_char  = r_char;
        n_wpend = 1'b0;
        n_waddr = r_waddr;
        rd_addr = r_ptr;
        we      = r_wpend;
        waddr   = r_waddr;
        wdata   = q;
        unique case (i_ctl.cmd)
            ile_pkg::CMD_LOAD: begin
                n_phase = 1'b0;
                n_char  = i_key_code[6:0];
                rd_addr = r_cur;
                unique case (i_ctl.op)
                    ile_pkg::OP_LEFT: begin
                        if (r_cur != '0) begin
                            n_cur = r_cur - ONE;
                        end
                    end
                    ile_pkg::OP_RIGHT: begin
                        if (r_cur < r_len) begin
                            n_cur = r_cur + ONE;
                        end
                    end
                    ile_pkg::OP_HOME: begin
                        n_cur = '0;
                    end
                    ile_pkg::OP_END: begin
                        n_cur = r_len;
                    end
                    ile_pkg::OP_CANCEL: begin
                        n_len = '0;
                        n_cur = '0;
                    end
                    ile_pkg::OP_ENTER: begin
                        n_len   = '0;
                        n_cur   = '0;
                        n_ptr   = '0;
                        n_dst   = r_len;
                        rd_addr = '0;
                    end
                    ile_pkg::OP_DELETE: begin
                        n_dst = r_cur;
                        n_ptr = r_cur + ONE;
                    end
                    ile_pkg::OP_BKSP: begin
                        if (r_cur != '0) begin
                            n_cur = r_cur - ONE;
                            n_dst = r_cur - ONE;
                            n_ptr = r_cur;
                        end
                    end
                    ile_pkg::OP_CWORD: begin
                        n_ptr   = r_cur;
                        rd_addr = r_cur - ONE;
                    end
                    ile_pkg::OP_CDEL: begin
                        n_ptr = r_cur;
                    end
                    ile_pkg::OP_INSERT: begin
                        n_dst = r_len;
                    end
                    default: begin
                    end
                endcase
            end
            // Walk forward over a word, then over its trailing blanks
            ile_pkg::CMD_SCAN_F: begin
                if (o_sts.stop_f) begin
                    n_dst = r_cur;
                end else if (!r_phase && blank_q) begin
                    n_phase = 1'b1;
                end else begin
                    n_ptr = r_ptr + ONE;
                end
                rd_addr = n_ptr;
            end
            // Walk back over blanks, then over the word before them
            ile_pkg::CMD_SCAN_B: begin
                if (o_sts.stop_b) begin
                    n_dst = r_ptr;
                    n_cur = r_ptr;
                    n_ptr = r_cur;
                end else if (!r_phase && !blank_q) begin
                    n_phase = 1'b1;
                end else begin
                    n_ptr = r_ptr - ONE;
                end
                rd_addr = n_ptr - ONE;
            end
            // Close the gap: read the source, write it in the next cycle
            ile_pkg::CMD_CUT: begin
                rd_addr = r_ptr;
                n_wpend = o_sts.cut_more;
                n_waddr = r_dst;
                if (o_sts.cut_more) begin
                    n_ptr = r_ptr + ONE;
                    n_dst = r_dst + ONE;
                end
            end
            ile_pkg::CMD_CUT_END: begin
                n_len = r_dst;
            end
            // Open a gap at the cursor, walking down from the end
            ile_pkg::CMD_INS: begin
                rd_addr = r_dst - ONE;
                n_wpend = o_sts.ins_more;
                n_waddr = r_dst;
                if (o_sts.ins_more) begin
                    n_dst = r_dst - ONE;
                end
            end
            ile_pkg::CMD_PUT: begin
                we    = 1'b1;
                waddr = r_cur;
                wdata = r_char;
                n_len = r_len + ONE;
                n_cur = r_cur + ONE;
            end
            ile_pkg::CMD_EMIT: begin
                n_ptr   = r_ptr + ONE;
                rd_addr = r_ptr + ONE;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cur    <= '0;
            r_wpend  <= 1'b0;
            r_phase  <= 1'b0;
            r_cap    <= ile_pkg::CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_cur    <= n_cur;
            r_wpend  <= n_wpend;
            r_phase  <= n_phase;
            r_strobe <= i_ctl.res;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_dst      <= n_dst;
        r_waddr    <= n_waddr;
        r_char     <= n_char;
        r_o_status <= i_ctl.res_status;
        r_o_len    <= ile_pkg::t_pos'(n_len);
        r_o_cur    <= ile_pkg::t_pos'(n_cur);
        r_o_char   <= emit ? q : '0;
        r_o_cv     <= emit;
        r_o_last   <= emit ? o_sts.emit_last : 1'b1;
    end

    assign o_strobe          = r_strobe;
    assign o_status          = r_o_status;
    assign o_line_length     = r_o_len;
    assign o_cursor_position = r_o_cur;
    assign o_out_char        = r_o_char;
    assign o_char_valid      = r_o_cv;
    assign o_last            = r_o_last;

endmodule

@@ hw/rtl/interactive_line_editor.sv @@
// ============================================================================
// interactive_line_editor - key-driven line editor with cursor
// Top level: joins the sequencer and the datapath and carries the checks.
// ============================================================================
// A key is taken when start is high and busy is low; every key gives one
// status beat on o_strobe in the cycle after it completes, and an accepted
// line gives one beat per character on consecutive cycles, the last one
// flagged. Beats cannot be held off. Cursor moves, ignored codes, cancel and
// refused edits complete in the accepting cycle (busy stays low). Edits that
// change the line walk the single-port-write line store one entry per cycle,
// with busy high throughout; a word delete first scans over the characters
// it passes, then closes the gap. Accepting a non-empty line keeps busy high
// while its characters are sent.
module interactive_line_editor #(
    parameter int LINE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [8:0] i_key_code,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output logic       o_strobe,
    output logic [1:0] o_status,
    output logic [5:0] o_line_length,
    output logic [5:0] o_cursor_position,
    output logic [6:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_last
);

    ile_pkg::t_ctl    ctl;
    ile_pkg::t_sts    sts;
    ile_pkg::t_status status;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_key_code (i_key_code),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_busy     (busy)
    );

    ile_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_key_code        (i_key_code),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_sts             (sts),
        .o_strobe          (o_strobe),
        .o_status          (status),
        .o_line_length     (o_line_length),
        .o_cursor_position (o_cursor_position),
        .o_out_char        (o_out_char),
        .o_char_valid      (o_char_valid),
        .o_last            (o_last)
    );

    assign o_status = status;

    // An empty key answers on the next beat, alone and final
    a_none_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_key_code == ile_pkg::KC_NONE)
            |=> (o_strobe && o_last && status == ile_pkg::ST_NO_INPUT))
        else $error("no-key item did not give a final no-input beat");

    // Line emission runs on consecutive cycles until the last character
    a_emit_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside accepted line emission");

    // Emitted characters report the cleared line
    a_emit_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_char_valid)
            |-> (status == ile_pkg::ST_ACCEPTED && o_line_length == '0
                 && o_cursor_position == '0))
        else $error("emitted character with uncleared length or cursor");

    // A long edit starts without a beat of its own
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_strobe)
        else $error("beat issued as a multi-cycle edit began");

endmodule

@@ dv/tb_interactive_line_editor.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_interactive_line_editor - self-checking bench for the line editor
// Drives key codes over the start/busy handshake, keeps a shadow copy of the
// line, cursor and capacity, and checks every status and character beat
// against it. Runs directed keys, then random editing sessions over several
// capacity settings and sender idling rates.
// ============================================================================
module tb_interactive_line_editor;
    import ile_pkg::*;

    localparam int DEPTH        = 64;
    localparam int SETTLE_GAP   = 2 * DEPTH;
    localparam int TAIL_CYCLES  = 4 * DEPTH;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        t_status status;
        t_pos    length;
        t_pos    cursor;
        t_char   ch;
        logic    valid;
        logic    last;
    } t_beat;

    typedef struct {
        t_key key;
        bit   drain;
    } t_key_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       drv_start = 1'b0;
    t_key       drv_key = '0;
    logic       cfg_we = 1'b0;
    t_cap       cfg_wdata = '0;
    logic       busy;
    logic       o_strobe;
    logic [1:0] o_status;
    logic [5:0] o_line_length;
    logic [5:0] o_cursor_position;
    logic [6:0] o_out_char;
    logic       o_char_valid;
    logic       o_last;

    // Shadow of the editor state
    t_char      shadow_line [DEPTH];
    int         shadow_len = 0;
    int         shadow_cur = 0;
    int         shadow_cap = CAP_RESET;

    t_key_item  key_queue [$];
    t_beat      awaited_beats [$];
    int         keys_issued = 0;
    int         keys_accepted = 0;
    int         send_idle_pct = 0;
    int         quiet_cycles = 0;
    int         errors = 0;

    interactive_line_editor #(.LINE_DEPTH(DEPTH)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (drv_start),
        .busy              (busy),
        .i_key_code        (drv_key),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_line_length     (o_line_length),
        .o_cursor_position (o_cursor_position),
        .o_out_char        (o_out_char),
        .o_char_valid      (o_char_valid),
        .o_last            (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Line prediction
    // ------------------------------------------------------------------
    function automatic bit blank_char(input t_char ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic void queue_beat(input t_status st, input t_char ch,
                                       input logic valid, input logic last);
        t_beat b;
        b.status = st;
        b.length = t_pos'(shadow_len);
        b.cursor = t_pos'(shadow_cur);
        b.ch     = ch;
        b.valid  = valid;
        b.last   = last;
        awaited_beats.push_back(b);
    endfunction

    // Remove [from, to) from the line and close the gap
    function automatic void cut_span(input int from, input int to);
        int gap;
        int i;
        gap = to - from;
        for (i = to; i < shadow_len; i++)
            shadow_line[i - gap] = shadow_line[i];
        shadow_len -= gap;
    endfunction

    task automatic apply_key(input t_key k);
        int len;
        int cur;
        int e;
        int i;
        int cap;
        len = shadow_len;
        cur = shadow_cur;
        e   = cur;
        if (k == KC_NONE) begin
            queue_beat(ST_NO_INPUT, '0, 1'b0, 1'b1);
            return;
        end
        if (k == KC_LEFT) begin
            if (cur > 0) shadow_cur = cur - 1;
        end else if (k == KC_RIGHT) begin
            if (cur < len) shadow_cur = cur + 1;
        end else if (k == KC_DELETE) begin
            if (cur < len) cut_span(cur, cur + 1);
        end else if (k == KC_HOME) begin
            shadow_cur = 0;
        end else if (k == KC_END) begin
            shadow_cur = len;
        end else if (k == KC_CTRL_DELETE) begin
            // Skip the word, then the blanks after it
            while (e < len && !blank_char(shadow_line[e])) e++;
            while (e < len && blank_char(shadow_line[e])) e++;
            if (e > cur) cut_span(cur, e);
        end else if (k == KC_LF || k == KC_CR) begin
            // Send the line out, one beat per character, after clearing
            shadow_len = 0;
            shadow_cur = 0;
            if (len == 0) begin
                queue_beat(ST_ACCEPTED, '0, 1'b0, 1'b1);
            end else begin
                for (i = 0; i < len; i++)
                    queue_beat(ST_ACCEPTED, shadow_line[i], 1'b1, i == len - 1);
            end
            return;
        end else if (k == KC_CTRL_C || k == KC_ESCAPE) begin
            shadow_len = 0;
            shadow_cur = 0;
            queue_beat(ST_CANCELLED, '0, 1'b0, 1'b1);
            return;
        end else if (k == KC_BACKSPACE || k == KC_DEL_ASCII) begin
            if (cur > 0) begin
                cut_span(cur - 1, cur);
                shadow_cur = cur - 1;
            end else if (len == 0) begin
                queue_beat(ST_CANCELLED, '0, 1'b0, 1'b1);
                return;
            end
        end else if (k == KC_CTRL_W) begin
            if (cur > 0) begin
                // Skip blanks backwards, then the word before them
                while (e > 0 && blank_char(shadow_line[e - 1])) e--;
                while (e > 0 && !blank_char(shadow_line[e - 1])) e--;
                cut_span(e, cur);
                shadow_cur = e;
            end else if (len == 0) begin
                queue_beat(ST_CANCELLED, '0, 1'b0, 1'b1);
                return;
            end
        end else if ((k >= KC_SPACE && k <= KC_TILDE) || k == KC_TAB) begin
            // Insert at the cursor while room is left for the terminator
            cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
            if (cap >= 1 && len < cap - 1) begin
                for (i = len; i > cur; i--)
                    shadow_line[i] = shadow_line[i - 1];
                shadow_line[cur] = t_char'(k);
                shadow_len = len + 1;
                shadow_cur = cur + 1;
            end
        end
        queue_beat(ST_CONTINUE, '0, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Key driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : key_driver
        logic      nxt_start;
        t_key      nxt_key;
        t_key_item it;
        nxt_start = drv_start;
        nxt_key   = drv_key;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (keys_accepted == keys_issued) begin
            // Previous key taken: offer the next key, idle, or hold off
            nxt_start = 1'b0;
            if (key_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(key_queue[0].drain && awaited_beats.size() != 0)) begin
                it = key_queue.pop_front();
                nxt_start = 1'b1;
                nxt_key   = it.key;
                keys_issued++;
            end
        end
        drv_start <= nxt_start;
        drv_key   <= nxt_key;
    end

    // ------------------------------------------------------------------
    // Result monitor and watchdog: sample on the rising edge
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_beat want;
        if (i_rst_n) begin
            quiet_cycles++;
            // Check a result beat before predicting the key taken this edge
            if (o_strobe === 1'b1) begin
                quiet_cycles = 0;
                if (awaited_beats.size() == 0) begin
                    $error("result beat with none awaited: status %0d len %0d",
                           o_status, o_line_length);
                    errors++;
                end else begin
                    want = awaited_beats.pop_front();
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("line_length", 8'(want.length), 8'(o_line_length));
                    check_field("cursor_position", 8'(want.cursor),
                                8'(o_cursor_position));
                    check_field("out_char", 8'(want.ch), 8'(o_out_char));
                    check_field("char_valid", 8'(want.valid), 8'(o_char_valid));
                    check_field("last", 8'(want.last), 8'(o_last));
                end
            end
            if (drv_start && busy === 1'b0) begin
                quiet_cycles = 0;
                apply_key(drv_key);
                keys_accepted++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_key(input t_key k, input bit drain);
        key_queue.push_back('{key: k, drain: drain});
    endtask

    function automatic t_key text_char();
        if ($urandom_range(0, 4) == 0)
            return ($urandom_range(0, 1) != 0) ? KC_SPACE : KC_TAB;
        return t_key'($urandom_range(33, 126));
    endfunction

    // Mostly editing keys with random text, some noise over the full code range
    function automatic t_key random_key();
        int w;
        w = $urandom_range(0, 99);
        if (w < 45) return text_char();
        if (w < 49) return KC_LEFT;
        if (w < 53) return KC_RIGHT;
        if (w < 55) return KC_HOME;
        if (w < 57) return KC_END;
        if (w < 61) return KC_DELETE;
        if (w < 65) return KC_CTRL_DELETE;
        if (w < 68) return KC_BACKSPACE;
        if (w < 71) return KC_DEL_ASCII;
        if (w < 75) return KC_CTRL_W;
        if (w < 78) return KC_LF;
        if (w < 81) return KC_CR;
        if (w < 82) return KC_CTRL_C;
        if (w < 83) return KC_ESCAPE;
        if (w < 85) return KC_NONE;
        return t_key'($urandom_range(0, 511));
    endfunction

    task automatic add_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_key(random_key(), $urandom_range(0, 15) == 0);
    endtask

    // Wait for every key taken and every beat seen, then let the block settle
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (key_queue.size() != 0 || keys_issued != keys_accepted
               || awaited_beats.size() != 0);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_capacity(input t_cap value);
        @(negedge i_clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        shadow_cap = value;
        @(negedge i_clk);
        cfg_we     <= 1'b0;
    endtask

    initial begin : stimulus
        t_key opening [$];
        int   i;

        // Hold reset, then release it on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed keys at the reset capacity: cancels on an empty line,
        // empty accept, blanks, edits at the line ends, ignored codes
        opening = '{KC_NONE, KC_BACKSPACE, KC_CTRL_W, KC_LF,
                    t_key'("a"), KC_TAB, t_key'("b"), KC_SPACE, KC_TILDE, KC_SPACE,
                    KC_HOME, KC_BACKSPACE, KC_CTRL_W, KC_CTRL_DELETE, KC_RIGHT,
                    KC_DELETE, KC_END, KC_LEFT, KC_CTRL_W, 9'd0, 9'd200, 9'd511,
                    KC_CR, t_key'("x"), KC_ESCAPE, KC_CTRL_C};
        send_idle_pct = 0;
        for (i = 0; i < opening.size(); i++) push_key(opening[i], 1'b0);
        wait_quiet();

        // Capacity above the store depth: fill past full, accept the longest line
        write_capacity(7'd127);
        send_idle_pct = 26;
        for (i = 0; i < DEPTH + 2; i++) push_key(text_char(), 1'b0);
        push_key(KC_CR, 1'b1);
        add_random(6);
        wait_quiet();

        // Tiny line: inserts hit the full-line case often
        write_capacity(7'd5);
        send_idle_pct = 48;
        add_random(8);
        wait_quiet();

        // Capacities that refuse every insert
        write_capacity(7'd1);
        send_idle_pct = 0;
        push_key(t_key'("q"), 1'b0);
        push_key(KC_TAB, 1'b0);
        push_key(KC_LF, 1'b0);
        wait_quiet();
        write_capacity(7'd0);
        push_key(KC_SPACE, 1'b0);
        push_key(KC_BACKSPACE, 1'b0);
        wait_quiet();

        // Full capacity, no idling
        write_capacity(CAP_RESET);
        add_random(6);
        wait_quiet();

        // Mid capacity, heavy idling
        write_capacity(7'd20);
        send_idle_pct = 48;
        add_random(6);
        wait_quiet();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
